// ----- hdl/cbz_pkg.sv -----
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared types and constants of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

    // Slice width of the multiplicand in the split multipliers
    localparam int MUL_CHUNK = 24;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_ONE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_TWO   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_THREE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_FOUR  = 2'd3;

    // Stage enables of one split multiplier
    typedef struct packed {
        logic pp;   // capture partial products
        logic acc;  // capture summed product
    } t_mul_en;

    // Stage enables of one blend unit
    typedef struct packed {
        logic pp;   // capture partial products
        logic acc;  // capture summed products
        logic sum;  // capture blended result
    } t_lerp_en;

endpackage

// ----- hdl/cbz_mul.sv -----
// ----------------------------------------------------------------------------
// cbz_mul
// Two-stage signed by unsigned multiplier: the multiplicand is cut into
// slices, slice products are registered, then shifted and summed.
// ----------------------------------------------------------------------------
module cbz_mul #(
    parameter int AW = 16,
    parameter int BW = 17
) (
    input  logic                        i_clk,
    input  cbz_pkg::t_mul_en            i_en,
    input  logic signed [AW-1:0]        i_a,
    input  logic        [BW-1:0]        i_b,
    output logic signed [AW+BW-1:0]     o_p
);

    localparam int CH  = cbz_pkg::MUL_CHUNK;
    localparam int NCH = (AW + CH - 1) / CH;
    localparam int PW  = NCH * CH;
    localparam int PPW = CH + BW + 2;
    localparam int OW  = AW + BW;

    logic signed [PW-1:0]  w_a_ext;
    logic signed [PPW-1:0] r_pp [NCH];
    logic signed [OW-1:0]  n_p;
    logic signed [OW-1:0]  r_p;

    assign w_a_ext = PW'(i_a);

    // Form one product per slice; only the top slice carries the sign
    for (genvar j = 0; j < NCH; j++) begin : g_pp
        if (j == NCH - 1) begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_en.pp) begin
                    r_pp[j] <= PPW'($signed(w_a_ext[j*CH +: CH]))
                               * PPW'($signed({1'b0, i_b}));
                end
            end
        end else begin : g_low
            always_ff @(posedge i_clk) begin
                if (i_en.pp) begin
                    r_pp[j] <= PPW'($signed({1'b0, w_a_ext[j*CH +: CH]}))
                               * PPW'($signed({1'b0, i_b}));
                end
            end
        end
    end

    // Align and add the slice products
    always_comb begin
        n_p = '0;
        for (int k = 0; k < NCH; k++) begin
            n_p = n_p + (OW'(r_pp[k]) <<< (k * CH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.acc) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ----- hdl/cbz_lerp.sv -----
// ----------------------------------------------------------------------------
// cbz_lerp
// Exact blend a*u + b*t with u + t = 1.0, three register stages:
// slice products, summed products, blended result.
// ----------------------------------------------------------------------------
module cbz_lerp #(
    parameter int IW = 16,
    parameter int TW = 17
) (
    input  logic                        i_clk,
    input  cbz_pkg::t_lerp_en           i_en,
    input  logic signed [IW-1:0]        i_a,
    input  logic signed [IW-1:0]        i_b,
    input  logic        [TW-1:0]        i_u,
    input  logic        [TW-1:0]        i_t,
    output logic signed [IW+TW-2:0]     o_r
);

    localparam int OW = IW + TW;
    localparam int RW = IW + TW - 1;

    cbz_pkg::t_mul_en   w_mul_en;
    logic signed [OW-1:0] w_pa;
    logic signed [OW-1:0] w_pb;
    logic signed [OW:0]   w_sum;
    logic signed [RW-1:0] r_r;

    assign w_mul_en.pp  = i_en.pp;
    assign w_mul_en.acc = i_en.acc;

    cbz_mul #(.AW(IW), .BW(TW)) u_mul_a (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (i_a),
        .i_b   (i_u),
        .o_p   (w_pa)
    );

    cbz_mul #(.AW(IW), .BW(TW)) u_mul_b (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (i_b),
        .i_b   (i_t),
        .o_p   (w_pb)
    );

    // Add the two products; the blend gains TW-1 fraction bits
    assign w_sum = (OW+1)'(w_pa) + (OW+1)'(w_pb);

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_r <= w_sum[RW-1:0];
        end
    end

    assign o_r = r_r;

endmodule

// ----- hdl/cubic_bezier_point_eval.sv -----
// Throughput: one point per cycle unless the output stalls; each de Casteljau level
// takes three stages (slice products, product sum, blend add), plus clamp and rounding.
// A stalled output holds its run of full stages; bubbles ahead of that run still fill.
// Reset (synchronous, active low) empties the pipeline and clears all points.
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Evaluates a 3D cubic Bezier curve at parameter t by three levels of exact
// fixed-point blending, then rounds to nearest and saturates each axis.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [cbz_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [3*COORD_BITS-1:0]             i_cfg_data,
    // parameter input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [T_FRAC_BITS:0]                i_param_t,
    // point output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_BITS-1:0]        o_coord_x,
    output logic signed [COORD_BITS-1:0]        o_coord_y,
    output logic signed [COORD_BITS-1:0]        o_coord_z
);

    localparam int C   = COORD_BITS;
    localparam int TF  = T_FRAC_BITS;
    localparam int TW  = TF + 1;
    localparam int W1  = C + TF;
    localparam int W2  = C + 2*TF;
    localparam int W3  = C + 3*TF;
    localparam int NST = 11;
    localparam int NTU = 7;

    localparam logic [TW-1:0]      T_ONE = {1'b1, {TF{1'b0}}};
    localparam logic signed [W3:0] HALF  = (W3+1)'({1'b1, {(3*TF-1){1'b0}}});
    localparam logic [C-1:0]       C_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0]       C_MIN = {1'b1, {(C-1){1'b0}}};

    logic [3*C-1:0]   r_pt [4];
    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   w_en;
    logic [TW-1:0]    r_t [NTU];
    logic [TW-1:0]    r_u [NTU];
    logic [TW-1:0]    n_t;
    logic [C-1:0]     r_coord [3];
    cbz_pkg::t_lerp_en w_len [3];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_pt[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbz_pkg::REG_POINT_ONE:   r_pt[0] <= i_cfg_data;
                cbz_pkg::REG_POINT_TWO:   r_pt[1] <= i_cfg_data;
                cbz_pkg::REG_POINT_THREE: r_pt[2] <= i_cfg_data;
                cbz_pkg::REG_POINT_FOUR:  r_pt[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage k advances when the output is ready or when it or any stage after it is empty
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign w_en[k] = i_ready | ~(&r_vld[NST-1:k]);
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NST-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Clamp t to 1.0 and form u = 1 - t
    assign n_t = (i_param_t > T_ONE) ? T_ONE : i_param_t;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_t[0] <= n_t;
            r_u[0] <= T_ONE - n_t;
        end
        for (int k = 1; k < NTU; k++) begin
            if (w_en[k]) begin
                r_t[k] <= r_t[k-1];
                r_u[k] <= r_u[k-1];
            end
        end
    end

    // Stage enables of each blend level
    for (genvar lv = 0; lv < 3; lv++) begin : g_len
        assign w_len[lv].pp  = w_en[3*lv+1];
        assign w_len[lv].acc = w_en[3*lv+2];
        assign w_len[lv].sum = w_en[3*lv+3];
    end

    // One de Casteljau tree per axis
    for (genvar ax = 0; ax < 3; ax++) begin : g_ax
        logic signed [C-1:0]  w_p  [4];
        logic signed [W1-1:0] w_l1 [3];
        logic signed [W2-1:0] w_l2 [2];
        logic signed [W3-1:0] w_l3;
        logic signed [W3:0]   w_rnd;
        logic        [C:0]    w_q;
        logic        [C-1:0]  n_coord;

        for (genvar j = 0; j < 4; j++) begin : g_pt
            assign w_p[j] = r_pt[j][ax*C +: C];
        end

        for (genvar j = 0; j < 3; j++) begin : g_l1
            cbz_lerp #(.IW(C), .TW(TW)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_len[0]),
                .i_a   (w_p[j]),
                .i_b   (w_p[j+1]),
                .i_u   (r_u[0]),
                .i_t   (r_t[0]),
                .o_r   (w_l1[j])
            );
        end

        for (genvar j = 0; j < 2; j++) begin : g_l2
            cbz_lerp #(.IW(W1), .TW(TW)) u_lerp (
                .i_clk (i_clk),
                .i_en  (w_len[1]),
                .i_a   (w_l1[j]),
                .i_b   (w_l1[j+1]),
                .i_u   (r_u[3]),
                .i_t   (r_t[3]),
                .o_r   (w_l2[j])
            );
        end

        cbz_lerp #(.IW(W2), .TW(TW)) u_lerp3 (
            .i_clk (i_clk),
            .i_en  (w_len[2]),
            .i_a   (w_l2[0]),
            .i_b   (w_l2[1]),
            .i_u   (r_u[6]),
            .i_t   (r_t[6]),
            .o_r   (w_l3)
        );

        // Round half up, drop the fraction, saturate
        assign w_rnd = (W3+1)'(w_l3) + HALF;
        assign w_q   = w_rnd[W3:3*TF];

        always_comb begin
            if (w_q[C] != w_q[C-1]) begin
                n_coord = w_q[C] ? C_MIN : C_MAX;
            end else begin
                n_coord = w_q[C-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[NST-1]) begin
                r_coord[ax] <= n_coord;
            end
        end
    end

    assign o_coord_x = r_coord[0];
    assign o_coord_y = r_coord[1];
    assign o_coord_z = r_coord[2];

    // Clamped t and its complement always make exactly 1.0
    a_t_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ((r_t[0] <= T_ONE) && (TW'(r_t[0] + r_u[0]) == T_ONE)))
        else $error("clamped parameter out of range");

    // A full pipeline behind a stalled output takes no new item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_ready) |-> !o_ready)
        else $error("input taken while pipeline full and stalled");

    // An input transfer always lands in the first stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    // A stalled output stage keeps its valid flag and its x coordinate
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_coord[0])))
        else $error("stalled result dropped or changed");

endmodule
